>>> src/linear_diophantine_solver_assert.svh
// Assertion macros shared by the solver modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LINEAR_DIOPHANTINE_SOLVER_ASSERT_SVH
`define LINEAR_DIOPHANTINE_SOLVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lds_pkg.sv
package lds_pkg;

  // Machine word width; inputs are one bit narrower, intermediates twice as wide.
  localparam int unsigned WIDTH = 32;
  localparam int unsigned AW    = WIDTH - 1;
  localparam int unsigned DW    = 2 * WIDTH;
  localparam int unsigned SW    = WIDTH + 1;
  localparam int unsigned CW    = $clog2(DW + 1);

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    UOP_MUL,
    UOP_DIV_SHORT,
    UOP_DIV_LONG
  } lds_uop_e;

  // For a multiply, opa is the unsigned multiplier and opb the multiplicand.
  // For a divide, opa is the dividend and opb the divisor.
  typedef struct packed {
    lds_uop_e        op;
    logic [DW-1:0]   opa;
    logic [DW-1:0]   opb;
  } lds_req_t;

  // acc holds the product or the remainder, quo holds the quotient.
  typedef struct packed {
    logic            done;
    logic [DW-1:0]   acc;
    logic [DW-1:0]   quo;
  } lds_rsp_t;

  typedef struct packed {
    logic [AW-1:0] coef_a;
    logic [AW-1:0] coef_b;
    logic [AW-1:0] rhs_c;
  } lds_in_t;

  typedef struct packed {
    logic                    solvable;
    logic [AW-1:0]           sol_x;
    logic signed [WIDTH-1:0] sol_y;
  } lds_out_t;

endpackage

>>> src/lds_unit.sv
`include "linear_diophantine_solver_assert.svh"

module lds_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lds_pkg::lds_req_t req_i,
  output lds_pkg::lds_rsp_t rsp_o
);
  import lds_pkg::*;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV
  } unit_state_e;

  unit_state_e   state_q, state_d;
  logic          done_q, done_d;
  logic [DW-1:0] acc_q, acc_d;
  logic [DW-1:0] mcand_q, mcand_d;
  logic [DW-1:0] mplier_q, mplier_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;

  // Restoring division shifts the remainder and quotient pair left one bit per cycle.
  assign rem_sh = {acc_q, mplier_q[DW-1]};
  assign diff   = rem_sh - {1'b0, mcand_q};

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          acc_d   = '0;
          mcand_d = req_i.opb;
          case (req_i.op)
            UOP_MUL: begin
              mplier_d = req_i.opa;
              state_d  = U_MUL;
            end
            UOP_DIV_SHORT: begin
              mplier_d = {req_i.opa[WIDTH-1:0], {WIDTH{1'b0}}};
              cnt_d    = CW'(WIDTH);
              state_d  = U_DIV;
            end
            UOP_DIV_LONG: begin
              mplier_d = req_i.opa;
              cnt_d    = CW'(DW);
              state_d  = U_DIV;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      U_MUL: begin
        // Stops as soon as no multiplier bits remain.
        if (mplier_q == '0) begin
          done_d  = 1'b1;
          state_d = U_IDLE;
        end else begin
          if (mplier_q[0]) begin
            acc_d = acc_q + mcand_q;
          end
          mcand_d  = {mcand_q[DW-2:0], 1'b0};
          mplier_d = {1'b0, mplier_q[DW-1:1]};
        end
      end
      U_DIV: begin
        if (!diff[DW]) begin
          acc_d = diff[DW-1:0];
        end else begin
          acc_d = rem_sh[DW-1:0];
        end
        mplier_d = {mplier_q[DW-2:0], ~diff[DW]};
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          done_d  = 1'b1;
          state_d = U_IDLE;
        end
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    cnt_q    <= cnt_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.acc  = acc_q;
  assign rsp_o.quo  = mplier_q;

  `LDS_ASSERT_SAME(a_start_when_idle, start_i, state_q == U_IDLE, "unit started while busy")
  `LDS_ASSERT_NEXT(a_done_single, done_q, !done_q, "unit done held longer than one cycle")

endmodule

>>> src/lds_seq.sv
`include "linear_diophantine_solver_assert.svh"

module lds_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lds_pkg::lds_in_t  in_i,
  output logic              idle_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output lds_pkg::lds_out_t res_o,
  output logic              ustart_o,
  output lds_pkg::lds_req_t ureq_o,
  input  lds_pkg::lds_rsp_t ursp_i
);
  import lds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EU_CHK,
    S_EU_DIV,
    S_EU_MS,
    S_EU_MT,
    S_FIN_G,
    S_FN_DC,
    S_FN_DA,
    S_FN_DB,
    S_FN_MX,
    S_FN_MY,
    S_FN_DM,
    S_FN_MB,
    S_FN_MA,
    S_RESULT
  } seq_state_e;

  seq_state_e             state_q, state_d;
  logic                   ustart_q, ustart_d;
  lds_req_t               ureq_q, ureq_d;
  logic [AW-1:0]          a_q, a_d, b_q, b_d, c_q, c_d;
  logic [AW-1:0]          r0_q, r0_d, r1_q, r1_d, q_q, q_d;
  logic signed [SW-1:0]   s0_q, s0_d, s1_q, s1_d, t0_q, t0_d, t1_q, t1_d;
  logic signed [DW-1:0]   x_q, x_d, y_q, y_d, m_q, m_d;
  logic                   solv_q, solv_d;
  logic [DW-1:0]          x_abs;

  assign x_abs = x_q[DW-1] ? (~x_q + 1'b1) : x_q;

  always_comb begin
    state_d  = state_q;
    ustart_d = 1'b0;
    ureq_d   = ureq_q;
    a_d      = a_q;
    b_d      = b_q;
    c_d      = c_q;
    r0_d     = r0_q;
    r1_d     = r1_q;
    q_d      = q_q;
    s0_d     = s0_q;
    s1_d     = s1_q;
    t0_d     = t0_q;
    t1_d     = t1_q;
    x_d      = x_q;
    y_d      = y_q;
    m_d      = m_q;
    solv_d   = solv_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          a_d     = in_i.coef_a;
          b_d     = in_i.coef_b;
          c_d     = in_i.rhs_c;
          r0_d    = in_i.coef_a;
          r1_d    = in_i.coef_b;
          s0_d    = SW'(1);
          s1_d    = '0;
          t0_d    = '0;
          t1_d    = SW'(1);
          state_d = S_EU_CHK;
        end
      end
      S_EU_CHK: begin
        if (r1_q == '0) begin
          state_d = S_FIN_G;
        end else begin
          ustart_d = 1'b1;
          ureq_d   = '{UOP_DIV_SHORT, {{(DW-AW){1'b0}}, r0_q}, {{(DW-AW){1'b0}}, r1_q}};
          state_d  = S_EU_DIV;
        end
      end
      S_EU_DIV: begin
        if (ursp_i.done) begin
          q_d      = ursp_i.quo[AW-1:0];
          r0_d     = r1_q;
          r1_d     = ursp_i.acc[AW-1:0];
          ustart_d = 1'b1;
          ureq_d   = '{UOP_MUL, {{(DW-AW){1'b0}}, ursp_i.quo[AW-1:0]},
                       {{(DW-SW){s1_q[SW-1]}}, s1_q}};
          state_d  = S_EU_MS;
        end
      end
      S_EU_MS: begin
        if (ursp_i.done) begin
          s0_d     = s1_q;
          s1_d     = s0_q - $signed(ursp_i.acc[SW-1:0]);
          ustart_d = 1'b1;
          ureq_d   = '{UOP_MUL, {{(DW-AW){1'b0}}, q_q}, {{(DW-SW){t1_q[SW-1]}}, t1_q}};
          state_d  = S_EU_MT;
        end
      end
      S_EU_MT: begin
        if (ursp_i.done) begin
          t0_d    = t1_q;
          t1_d    = t0_q - $signed(ursp_i.acc[SW-1:0]);
          state_d = S_EU_CHK;
        end
      end
      S_FIN_G: begin
        // r0 now holds the gcd; a zero gcd means both coefficients were zero.
        if (r0_q == '0) begin
          solv_d  = (c_q == '0);
          x_d     = '0;
          y_d     = '0;
          state_d = S_RESULT;
        end else begin
          ustart_d = 1'b1;
          ureq_d   = '{UOP_DIV_SHORT, {{(DW-AW){1'b0}}, c_q}, {{(DW-AW){1'b0}}, r0_q}};
          state_d  = S_FN_DC;
        end
      end
      S_FN_DC: begin
        if (ursp_i.done) begin
          if (ursp_i.acc[AW-1:0] != '0) begin
            solv_d  = 1'b0;
            x_d     = '0;
            y_d     = '0;
            state_d = S_RESULT;
          end else begin
            c_d      = ursp_i.quo[AW-1:0];
            ustart_d = 1'b1;
            ureq_d   = '{UOP_DIV_SHORT, {{(DW-AW){1'b0}}, a_q}, {{(DW-AW){1'b0}}, r0_q}};
            state_d  = S_FN_DA;
          end
        end
      end
      S_FN_DA: begin
        if (ursp_i.done) begin
          a_d      = ursp_i.quo[AW-1:0];
          ustart_d = 1'b1;
          ureq_d   = '{UOP_DIV_SHORT, {{(DW-AW){1'b0}}, b_q}, {{(DW-AW){1'b0}}, r0_q}};
          state_d  = S_FN_DB;
        end
      end
      S_FN_DB: begin
        if (ursp_i.done) begin
          b_d = ursp_i.quo[AW-1:0];
          if (ursp_i.quo[AW-1:0] == '0) begin
            // With no y term the solution for x is unique.
            solv_d  = 1'b1;
            x_d     = {{(DW-AW){1'b0}}, c_q};
            y_d     = '0;
            state_d = S_RESULT;
          end else begin
            ustart_d = 1'b1;
            ureq_d   = '{UOP_MUL, {{(DW-AW){1'b0}}, c_q}, {{(DW-SW){s0_q[SW-1]}}, s0_q}};
            state_d  = S_FN_MX;
          end
        end
      end
      S_FN_MX: begin
        if (ursp_i.done) begin
          x_d      = ursp_i.acc;
          ustart_d = 1'b1;
          ureq_d   = '{UOP_MUL, {{(DW-AW){1'b0}}, c_q}, {{(DW-SW){t0_q[SW-1]}}, t0_q}};
          state_d  = S_FN_MY;
        end
      end
      S_FN_MY: begin
        if (ursp_i.done) begin
          y_d      = ursp_i.acc;
          ustart_d = 1'b1;
          ureq_d   = '{UOP_DIV_LONG, x_abs, {{(DW-AW){1'b0}}, b_q}};
          state_d  = S_FN_DM;
        end
      end
      S_FN_DM: begin
        if (ursp_i.done) begin
          // Floor quotient: a negative x with a remainder rounds one further down.
          if (x_q[DW-1]) begin
            m_d = ~ursp_i.quo + {{(DW-1){1'b0}}, (ursp_i.acc == '0)};
          end else begin
            m_d = ursp_i.quo;
          end
          ustart_d = 1'b1;
          ureq_d   = '{UOP_MUL, {{(DW-AW){1'b0}}, b_q}, m_d};
          state_d  = S_FN_MB;
        end
      end
      S_FN_MB: begin
        if (ursp_i.done) begin
          x_d      = x_q - $signed(ursp_i.acc);
          ustart_d = 1'b1;
          ureq_d   = '{UOP_MUL, {{(DW-AW){1'b0}}, a_q}, m_q};
          state_d  = S_FN_MA;
        end
      end
      S_FN_MA: begin
        if (ursp_i.done) begin
          y_d     = y_q + $signed(ursp_i.acc);
          solv_d  = 1'b1;
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ustart_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ustart_q <= ustart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ureq_q <= ureq_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    r0_q   <= r0_d;
    r1_q   <= r1_d;
    q_q    <= q_d;
    s0_q   <= s0_d;
    s1_q   <= s1_d;
    t0_q   <= t0_d;
    t1_q   <= t1_d;
    x_q    <= x_d;
    y_q    <= y_d;
    m_q    <= m_d;
    solv_q <= solv_d;
  end

  assign idle_o         = (state_q == S_IDLE);
  assign res_valid_o    = (state_q == S_RESULT);
  assign res_o.solvable = solv_q;
  assign res_o.sol_x    = x_q[AW-1:0];
  assign res_o.sol_y    = y_q[WIDTH-1:0];
  assign ustart_o       = ustart_q;
  assign ureq_o         = ureq_q;

  `LDS_ASSERT_SAME(a_unsolvable_zero, (state_q == S_RESULT) && !solv_q, (x_q == '0) && (y_q == '0), "unsolvable result carries a nonzero solution")
  `LDS_ASSERT_SAME(a_x_in_range, (state_q == S_RESULT) && solv_q && (b_q != '0), !x_q[DW-1] && (x_q < {{(DW-AW){1'b0}}, b_q}), "x outside its least residue range")

endmodule

>>> src/linear_diophantine_solver.sv
// Solves a*x + b*y = c for non-negative 31-bit a, b and c, one equation per input beat.
// Each result beat gives solvable, the least non-negative x (0 <= x < b/g with
// g = gcd(a, b)) and the matching y in two's complement; both are zero when g does
// not divide c. All arithmetic goes through one shared shift-add multiplier and
// restoring divider that retires one bit per cycle. Each extended Euclid step costs
// a short division plus two multiplications whose length follows the bit length
// of that step's quotient. The closing phase adds three short divisions, one long
// floor division and four multiplications; an equation without a solution stops
// right after the gcd test. An equation is quickest when both coefficients are
// zero and slowest for the longest Euclid chains. The input is not ready while
// an equation is being worked on; the finished result sits in an output register,
// so the next equation is taken as soon as the previous one has been handed to
// that register.
`include "linear_diophantine_solver_assert.svh"

module linear_diophantine_solver (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lds_pkg::lds_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lds_pkg::lds_out_t out_data_o
);
  import lds_pkg::*;

  logic     seq_idle;
  logic     seq_res_valid;
  logic     seq_res_ready;
  lds_out_t seq_res;
  logic     ustart;
  lds_req_t ureq;
  lds_rsp_t ursp;
  logic     out_valid_q, out_valid_d;
  lds_out_t out_data_q;

  // The sequencer walks the Euclid recurrence and the final scaling, issuing one
  // multiply or divide at a time to the shared unit.
  lds_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && seq_idle),
    .in_i        (in_data_i),
    .idle_o      (seq_idle),
    .res_valid_o (seq_res_valid),
    .res_ready_i (seq_res_ready),
    .res_o       (seq_res),
    .ustart_o    (ustart),
    .ureq_o      (ureq),
    .ursp_i      (ursp)
  );

  lds_unit u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ustart),
    .req_i   (ureq),
    .rsp_o   (ursp)
  );

  // The output register frees the sequencer as soon as it is empty or being drained.
  assign seq_res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_res_valid && seq_res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_valid && seq_res_ready) begin
      out_data_q <= seq_res;
    end
  end

  assign in_ready_o  = seq_idle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A result can only be loaded while no new equation is being taken in.
  `LDS_ASSERT_SAME(a_no_load_on_accept, seq_res_valid, !in_ready_o, "result pending while input ready")

endmodule

>>> test/linear_diophantine_solver_tb.sv
`timescale 1ns / 1ps

module linear_diophantine_solver_tb;
  import lds_pkg::*;

  localparam int unsigned FIELD_TOP = 32'({AW{1'b1}});
  localparam int unsigned RANDOM_EQS = 300;
  localparam int unsigned IDLE_PCT = 18;
  localparam int unsigned HOLD_CYCLES = 6000;

  // One accepted equation together with the solution it must produce.
  typedef struct {
    lds_in_t  eq;
    lds_out_t sol;
  } solution_due_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     eq_valid = 1'b0;
  logic     eq_ready;
  lds_in_t  eq_data = '0;
  logic     sol_valid;
  logic     sol_ready = 1'b0;
  lds_out_t sol_data;
  logic     hold_results = 1'b0;

  lds_in_t       equations_todo[$];
  solution_due_t solutions_due[$];
  solution_due_t oldest_due;

  int unsigned total_eqs = 0;
  int unsigned eqs_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned solvable_seen = 0;
  int unsigned unsolvable_seen = 0;
  int unsigned error_count = 0;

  linear_diophantine_solver u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (eq_valid),
    .in_ready_o (eq_ready),
    .in_data_i  (eq_data),
    .out_valid_o(sol_valid),
    .out_ready_i(sol_ready),
    .out_data_o (sol_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Extended Euclid on 64-bit signed values, then the shift that brings x into
  // the range 0 <= x < b/g. Every intermediate stays well inside 64 bits.
  function automatic lds_out_t solve_equation(lds_in_t eq);
    longint   a, b, c, r0, r1, s0, s1, t0, t1, q, nxt, g, x, y, m;
    lds_out_t res;
    a = eq.coef_a;
    b = eq.coef_b;
    c = eq.rhs_c;
    r0 = a;
    r1 = b;
    s0 = 1;
    s1 = 0;
    t0 = 0;
    t1 = 1;
    res = '0;
    while (r1 != 0) begin
      q = r0 / r1;
      nxt = r0 - q * r1;
      r0 = r1;
      r1 = nxt;
      nxt = s0 - q * s1;
      s0 = s1;
      s1 = nxt;
      nxt = t0 - q * t1;
      t0 = t1;
      t1 = nxt;
    end
    g = r0;
    // With both coefficients zero only c = 0 has a solution, namely x = y = 0.
    if (g == 0) begin
      res.solvable = (c == 0);
      return res;
    end
    if (c % g != 0) return res;
    a = a / g;
    b = b / g;
    c = c / g;
    x = s0 * c;
    y = t0 * c;
    if (b == 0) begin
      // Coefficient b is zero, so x is unique and y is taken as zero.
      x = c;
      y = 0;
    end else begin
      m = x / b;
      if ((x % b) != 0 && ((x < 0) != (b < 0))) m = m - 1;
      x = x - m * b;
      y = y + m * a;
    end
    res.solvable = 1'b1;
    res.sol_x = x[AW-1:0];
    res.sol_y = y[WIDTH-1:0];
    return res;
  endfunction

  // Operand with a spread of magnitudes: full range, tiny, close to the top,
  // single bits and randomly truncated values.
  function automatic logic [AW-1:0] draw_operand();
    int unsigned pick;
    int unsigned val;
    pick = $urandom_range(99);
    if (pick < 55) val = $urandom();
    else if (pick < 70) val = $urandom_range(255);
    else if (pick < 80) val = FIELD_TOP - $urandom_range(255);
    else if (pick < 90) val = 1 << $urandom_range(AW - 1);
    else val = $urandom() >> $urandom_range(AW - 1);
    return val[AW-1:0];
  endfunction

  function automatic lds_in_t draw_equation();
    lds_in_t     eq;
    int unsigned pick, g, lim, k, fa, fb, nxt, steps;
    pick = $urandom_range(99);
    if (pick < 60) begin
      eq.coef_a = draw_operand();
      eq.coef_b = draw_operand();
      eq.rhs_c = draw_operand();
    end else if (pick < 85) begin
      // Coefficients with a common factor; c is a multiple of it about half
      // the time, otherwise it leaves a remainder and there is no solution.
      g = 2 + $urandom_range(1 << $urandom_range(20));
      lim = FIELD_TOP / g;
      eq.coef_a = AW'(g * $urandom_range(lim, 1));
      eq.coef_b = AW'(g * $urandom_range(lim, 1));
      k = $urandom_range(lim - 1, 0);
      if ($urandom_range(1) == 0) eq.rhs_c = AW'(g * k);
      else eq.rhs_c = AW'(g * k + $urandom_range(g - 1, 1));
    end else begin
      // Neighboring Fibonacci numbers give the longest Euclid chains.
      fa = 1;
      fb = 1;
      steps = $urandom_range(44, 2);
      for (int unsigned i = 0; i < steps; i++) begin
        nxt = fa + fb;
        fa = fb;
        fb = nxt;
      end
      if ($urandom_range(1) == 0) begin
        eq.coef_a = AW'(fb);
        eq.coef_b = AW'(fa);
      end else begin
        eq.coef_a = AW'(fa);
        eq.coef_b = AW'(fb);
      end
      eq.rhs_c = draw_operand();
    end
    return eq;
  endfunction

  task automatic queue_equation(input int unsigned a, input int unsigned b,
                                input int unsigned c);
    lds_in_t eq;
    eq.coef_a = AW'(a);
    eq.coef_b = AW'(b);
    eq.rhs_c = AW'(c);
    equations_todo.push_back(eq);
  endtask

  // Printing stops after a hundred lines so that a broken block cannot flood
  // the log, but every mismatch is still counted.
  task automatic log_mismatch(input string msg);
    if (error_count < 100) $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Sender side. A beat is taken at an edge where valid and ready are both
  // high; the expected solution is queued right then. A new equation is only
  // presented once the previous one has gone, and valid stays up until then.
  always @(posedge clk) begin
    if (!rst_n) begin
      eq_valid <= 1'b0;
    end else begin
      if (eq_valid && eq_ready) begin
        solutions_due.push_back('{eq: eq_data, sol: solve_equation(eq_data)});
        eqs_accepted++;
      end
      if (!eq_valid || eq_ready) begin
        // Equations 150 to 199 go in back to back with no gaps.
        if (equations_todo.size() != 0 &&
            ((eqs_accepted >= 150 && eqs_accepted < 200) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          eq_data <= equations_todo.pop_front();
          eq_valid <= 1'b1;
        end else begin
          eq_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side. Each result beat is checked against the oldest expected
  // solution. Ready drops at random except during a quiet window and is held
  // low entirely while the long stall is in force.
  always @(posedge clk) begin
    if (!rst_n) begin
      sol_ready <= 1'b0;
    end else begin
      if (sol_valid && sol_ready) begin
        if (solutions_due.size() == 0) begin
          log_mismatch("result beat arrived with no equation outstanding");
        end else begin
          oldest_due = solutions_due.pop_front();
          if (sol_data.solvable !== oldest_due.sol.solvable)
            log_mismatch($sformatf("a=%0d b=%0d c=%0d solvable got %b want %b",
              oldest_due.eq.coef_a, oldest_due.eq.coef_b, oldest_due.eq.rhs_c,
              sol_data.solvable, oldest_due.sol.solvable));
          if (sol_data.sol_x !== oldest_due.sol.sol_x)
            log_mismatch($sformatf("a=%0d b=%0d c=%0d x got %0d want %0d",
              oldest_due.eq.coef_a, oldest_due.eq.coef_b, oldest_due.eq.rhs_c,
              sol_data.sol_x, oldest_due.sol.sol_x));
          if (sol_data.sol_y !== oldest_due.sol.sol_y)
            log_mismatch($sformatf("a=%0d b=%0d c=%0d y got %0d want %0d",
              oldest_due.eq.coef_a, oldest_due.eq.coef_b, oldest_due.eq.rhs_c,
              sol_data.sol_y, oldest_due.sol.sol_y));
          if (oldest_due.sol.solvable) solvable_seen++;
          else unsolvable_seen++;
        end
        results_checked++;
      end
      sol_ready <= !hold_results &&
                   ((results_checked >= 150 && results_checked < 200) ||
                    $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Long receiver stall: the block finishes one equation into its output
  // register, takes and solves the next, and then has to refuse input while
  // the sender keeps offering.
  initial begin
    wait (rst_n && results_checked >= 40);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  initial begin
    // Directed equations: field extremes, zero coefficients and right-hand
    // sides, missing solutions, large common factors and a long Euclid chain.
    queue_equation(1, 1, 1);
    queue_equation(FIELD_TOP, FIELD_TOP, FIELD_TOP);
    queue_equation(0, 0, 0);
    queue_equation(0, 0, 5);
    queue_equation(3, 0, 12);
    queue_equation(5, 0, 12);
    queue_equation(FIELD_TOP, 0, FIELD_TOP);
    queue_equation(0, 4, 12);
    queue_equation(0, 4, 13);
    queue_equation(6, 9, 0);
    queue_equation(6, 9, 4);
    queue_equation(6, 9, 21);
    queue_equation(1836311903, 1134903170, FIELD_TOP);
    queue_equation(1134903170, 1836311903, 1);
    queue_equation(1, FIELD_TOP, FIELD_TOP);
    queue_equation(FIELD_TOP, 1, 1);
    queue_equation(1 << 30, 1 << 30, 1 << 30);
    queue_equation(1 << 30, 1 << 29, (1 << 30) + (1 << 29));
    queue_equation(1 << 30, 1 << 29, 1);
    queue_equation(2, FIELD_TOP, 1);
    queue_equation(FIELD_TOP, FIELD_TOP - 1, 1);
    queue_equation(FIELD_TOP - 1, FIELD_TOP, FIELD_TOP);
    repeat (RANDOM_EQS) equations_todo.push_back(draw_equation());
    total_eqs = equations_todo.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (eqs_accepted == total_eqs);
    while (solutions_due.size() != 0) @(posedge clk);
    // Every equation yields a result, so a short drain catches stray beats.
    repeat (100) @(posedge clk);

    $display("Solved %0d of %0d equations: %0d with a solution, %0d without.",
             results_checked, total_eqs, solvable_seen, unsolvable_seen);
    $display("Traffic had random gaps on both sides and one %0d-cycle output stall.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Roughly six times the slowest correct run.
  initial begin
    #40_000_000;
    $display("Timeout with %0d of %0d equations accepted.", eqs_accepted, total_eqs);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
